[hdl/motor_speed_pid_regulator_defines.svh]
// Assertion macros shared by the motor speed regulator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MOTOR_SPEED_PID_REGULATOR_DEFINES_SVH
`define MOTOR_SPEED_PID_REGULATOR_DEFINES_SVH

// Checked on every rising edge, masked while reset is asserted.
`define MSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define MSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/msp_pkg.sv]
// Shared types, widths and constants of the motor speed regulator.
// No dependencies; imported by every module of the block.
package msp_pkg;

    localparam int GAIN_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int TGT_W      = 16;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int ERR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W;
    localparam int DIV_W      = 49;
    localparam int DVS_W      = TIME_W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int INTEG_W    = 26;
    localparam int T_W        = 52;
    localparam int FRAC_W     = 16;

    typedef enum logic [1:0] {
        M_COAST = 2'd0,
        M_BRAKE = 2'd1,
        M_SPEED = 2'd2,
        M_HOLD  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP   = 3'd0,
        REG_INTEG  = 3'd1,
        REG_DERIV  = 3'd2,
        REG_FF     = 3'd3,
        REG_PERIOD = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MS_CHANGE = 3'd0,
        MS_INTEG  = 3'd1,
        MS_DERIV  = 3'd2,
        MS_PROP   = 3'd3,
        MS_FF     = 3'd4
    } t_mul_sel;

    localparam logic signed [MUL_W-1:0] SPEED_SCALE = MUL_W'(1000);
    localparam logic signed [ACC_W-1:0] INTEG_LIM   = ACC_W'(255 * 65536);
    localparam logic signed [T_W-1:0]   DRIVE_MAX   = T_W'(255);
    localparam logic signed [T_W-1:0]   DRIVE_MIN   = T_W'(-255);
    localparam logic [DUTY_W-1:0]       DUTY_FULL   = 8'd255;

    typedef struct packed {
        logic     load;
        logic     decide;
        logic     zero_speed;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     div_deriv;
        logic     speed_load;
        logic     err_load;
        logic     integ_load;
        logic     acc_load;
        logic     acc_add;
        logic     sum;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic stopped;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

[hdl/msp_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on msp_pkg and the assertion macro header.
`include "motor_speed_pid_regulator_defines.svh"
module msp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [msp_pkg::DIV_W-1:0]   i_dividend,
    input  logic [msp_pkg::DVS_W-1:0]   i_divisor,
    output logic [msp_pkg::DIV_W-1:0]   o_quot,
    output logic                        o_done
);
    import msp_pkg::*;

    logic [DVS_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_rem <= w_fits ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

    `MSP_ASSERT(a_start_restarts, i_clk, i_rst_n, i_start |=> (r_busy && !o_done), "divider did not restart")
    `MSP_ASSERT(a_done_after_last, i_clk, i_rst_n, $rose(o_done) |-> ($past(r_busy) && $past(r_cnt == '0)), "divider done early")
    `MSP_ASSERT(a_busy_done_excl, i_clk, i_rst_n, !(r_busy && r_done), "divider busy and done together")

endmodule

[hdl/msp_dpath.sv]
// Datapath: configuration, loop state, shared multiplier, PID sum and result register.
// Depends on msp_pkg; driven by msp_ctrl, uses the quotient of msp_div.
module msp_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  msp_pkg::t_cmd                    i_cmd,
    output msp_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                       i_mode,
    input  logic signed [msp_pkg::TGT_W-1:0] i_target_speed,
    input  logic signed [msp_pkg::POS_W-1:0] i_encoder_count,
    input  logic [msp_pkg::TIME_W-1:0]       i_now_ms,
    output logic [msp_pkg::DIV_W-1:0]       o_div_dividend,
    output logic [msp_pkg::DVS_W-1:0]       o_div_divisor,
    input  logic [msp_pkg::DIV_W-1:0]       i_div_quot,
    input  logic                             i_div_done,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [msp_pkg::DUTY_W-1:0]       o_fwd_duty,
    output logic [msp_pkg::DUTY_W-1:0]       o_rev_duty,
    output logic                             o_braking,
    output logic                             o_acted,
    output logic signed [msp_pkg::ERR_W-1:0] o_speed_error
);
    import msp_pkg::*;

    logic signed [GAIN_W-1:0]  r_prop, r_integ_g, r_deriv, r_ff;
    logic [PERIOD_W-1:0]       r_period;

    t_mode                     r_mode;
    logic signed [TGT_W-1:0]   r_target;
    logic [POS_W-1:0]          r_enc;
    logic [TIME_W-1:0]         r_now;

    logic [TIME_W-1:0]         r_last_time;
    logic [POS_W-1:0]          r_last_pos;
    logic signed [ERR_W-1:0]   r_speed;
    logic signed [ERR_W-1:0]   r_last_speed;
    logic signed [INTEG_W-1:0] r_integ;
    t_mode                     r_prev;
    logic [DUTY_W-1:0]         r_held_fwd, r_held_rev;
    logic                      r_held_brake;
    logic signed [ERR_W-1:0]   r_held_err;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_acted;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_div_neg;

    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_fwd, r_rev;
    logic                      r_brake, r_acted_o;
    logic signed [ERR_W-1:0]   r_err_o;

    logic [TIME_W-1:0]         w_elapsed;
    logic [PERIOD_W-1:0]       w_period;
    logic                      w_run;
    logic signed [POS_W-1:0]   w_change;
    logic signed [MUL_W-1:0]   w_dspeed;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_mul_p;
    logic [PROD_W-1:0]         w_prod_abs;
    logic [T_W-1:0]            w_qmag;
    logic signed [T_W-1:0]     w_qs;
    logic signed [T_W-1:0]     w_err_raw;
    logic signed [ACC_W-1:0]   w_isum;
    logic signed [INTEG_W-1:0] w_inew;
    logic signed [ACC_W-FRAC_W-1:0] w_q16;
    logic signed [T_W-1:0]     w_t, w_tc, w_tneg;
    logic [DUTY_W-1:0]         w_fin_fwd, w_fin_rev;
    logic                      w_fin_brake;

    function automatic logic signed [ERR_W-1:0] f_sat32(input logic signed [T_W-1:0] v);
        logic signed [ERR_W-1:0] res;
        if ((&v[T_W-1:ERR_W-1]) || !(|v[T_W-1:ERR_W-1])) begin
            res = v[ERR_W-1:0];
        end else if (v[T_W-1]) begin
            res = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ERR_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_elapsed = r_now - r_last_time;
    assign w_period  = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_run     = (r_mode == M_SPEED) && (w_elapsed >= TIME_W'(w_period));
    assign w_change  = r_enc - r_last_pos;
    assign w_dspeed  = MUL_W'(r_speed) - MUL_W'(r_last_speed);

    always_comb begin
        w_mul_a = MUL_W'(w_change);
        w_mul_b = SPEED_SCALE;
        case (i_cmd.mul_sel)
            MS_CHANGE: begin
                w_mul_a = MUL_W'(w_change);
                w_mul_b = SPEED_SCALE;
            end
            MS_INTEG: begin
                w_mul_a = MUL_W'(r_integ_g);
                w_mul_b = MUL_W'(r_err);
            end
            MS_DERIV: begin
                w_mul_a = MUL_W'(r_deriv);
                w_mul_b = w_dspeed;
            end
            MS_PROP: begin
                w_mul_a = MUL_W'(r_prop);
                w_mul_b = MUL_W'(r_err);
            end
            MS_FF: begin
                w_mul_a = MUL_W'(r_ff);
                w_mul_b = MUL_W'(r_target);
            end
            default: begin
                w_mul_a = MUL_W'(w_change);
                w_mul_b = SPEED_SCALE;
            end
        endcase
    end

    assign w_mul_p    = w_mul_a * w_mul_b;
    assign w_prod_abs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // The derivative divisor is elapsed * 2^16: drop 16 bits, then divide by elapsed.
    assign o_div_dividend = i_cmd.div_deriv ? w_prod_abs[DIV_W+FRAC_W-1:FRAC_W]
                                            : w_prod_abs[DIV_W-1:0];
    assign o_div_divisor  = w_elapsed;

    assign w_qmag = T_W'(i_div_quot);
    assign w_qs   = r_div_neg ? -signed'(w_qmag) : signed'(w_qmag);

    assign w_err_raw = T_W'(r_target) - T_W'(r_speed);

    always_comb begin
        w_isum = ACC_W'(r_integ) + r_prod;
        if (w_isum > INTEG_LIM) begin
            w_inew = INTEG_W'(INTEG_LIM);
        end else if (w_isum < -INTEG_LIM) begin
            w_inew = INTEG_W'(-INTEG_LIM);
        end else begin
            w_inew = INTEG_W'(w_isum);
        end
    end

    assign w_q16 = r_acc[ACC_W-1:FRAC_W];
    assign w_t   = T_W'(w_q16) - w_qs;

    // Clamp the drive to -255..255; round a negative drive toward zero when the sum had a fraction.
    always_comb begin
        if (w_t >= DRIVE_MAX) begin
            w_tc = DRIVE_MAX;
        end else if (w_t < DRIVE_MIN) begin
            w_tc = DRIVE_MIN;
        end else if (w_t[T_W-1] && (|r_acc[FRAC_W-1:0])) begin
            w_tc = w_t + T_W'(1);
        end else begin
            w_tc = w_t;
        end
    end
    assign w_tneg = -w_tc;

    always_comb begin
        case (r_mode)
            M_COAST: begin
                w_fin_fwd   = '0;
                w_fin_rev   = '0;
                w_fin_brake = 1'b0;
            end
            M_BRAKE: begin
                w_fin_fwd   = DUTY_FULL;
                w_fin_rev   = DUTY_FULL;
                w_fin_brake = 1'b1;
            end
            default: begin
                w_fin_fwd   = r_held_fwd;
                w_fin_rev   = r_held_rev;
                w_fin_brake = r_held_brake;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop    <= '0;
            r_integ_g <= '0;
            r_deriv   <= '0;
            r_ff      <= '0;
            r_period  <= PERIOD_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_PROP:   r_prop    <= i_cfg_wdata;
                REG_INTEG:  r_integ_g <= i_cfg_wdata;
                REG_DERIV:  r_deriv   <= i_cfg_wdata;
                REG_FF:     r_ff      <= i_cfg_wdata;
                REG_PERIOD: r_period  <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_pos   <= '0;
            r_speed      <= '0;
            r_last_speed <= '0;
            r_integ      <= '0;
            r_prev       <= M_COAST;
            r_held_fwd   <= '0;
            r_held_rev   <= '0;
            r_held_brake <= 1'b0;
            r_held_err   <= '0;
        end else begin
            if (i_cmd.zero_speed) begin
                r_speed <= '0;
                r_integ <= '0;
            end
            if (i_cmd.speed_load) begin
                r_speed <= f_sat32(w_qs);
            end
            if (i_cmd.integ_load) begin
                r_integ <= w_inew;
            end
            if (i_cmd.sum) begin
                r_held_fwd   <= w_tc[T_W-1] ? '0 : w_tc[DUTY_W-1:0];
                r_held_rev   <= w_tc[T_W-1] ? w_tneg[DUTY_W-1:0] : '0;
                r_held_brake <= 1'b0;
                r_held_err   <= r_err;
                r_last_speed <= r_speed;
                r_last_pos   <= r_enc;
                r_last_time  <= r_now;
                r_prev       <= M_SPEED;
            end
            if (i_cmd.finish && (r_mode == M_COAST || r_mode == M_BRAKE)) begin
                r_held_fwd   <= w_fin_fwd;
                r_held_rev   <= w_fin_rev;
                r_held_brake <= w_fin_brake;
                r_prev       <= r_mode;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= t_mode'(i_mode);
            r_target <= i_target_speed;
            r_enc    <= i_encoder_count;
            r_now    <= i_now_ms;
        end
        if (i_cmd.decide) begin
            r_acted <= (r_mode != M_SPEED) || w_run;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_p;
        end
        if (i_cmd.div_start) begin
            r_div_neg <= r_prod[PROD_W-1];
        end
        if (i_cmd.err_load) begin
            r_err <= f_sat32(w_err_raw);
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod + ACC_W'(r_integ);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fwd     <= w_fin_fwd;
            r_rev     <= w_fin_rev;
            r_brake   <= w_fin_brake;
            r_acted_o <= r_acted;
            r_err_o   <= r_held_err;
        end
    end

    assign o_stat.run      = w_run;
    assign o_stat.stopped  = (r_prev == M_COAST) || (r_prev == M_BRAKE);
    assign o_stat.div_done = i_div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_fwd_duty    = r_fwd;
    assign o_rev_duty    = r_rev;
    assign o_braking     = r_brake;
    assign o_acted       = r_acted_o;
    assign o_speed_error = r_err_o;

endmodule

[hdl/msp_ctrl.sv]
// Sequencer of one poll request: decide, measure speed, PID terms, drive sum.
// Depends on msp_pkg; commands msp_dpath and msp_div.
module msp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msp_pkg::t_stat i_stat,
    output msp_pkg::t_cmd  o_cmd
);
    import msp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECIDE = 13'b0000000000010,
        S_DIVS   = 13'b0000000000100,
        S_DIVSW  = 13'b0000000001000,
        S_ERR    = 13'b0000000010000,
        S_MULI   = 13'b0000000100000,
        S_ACCI   = 13'b0000001000000,
        S_DIVD   = 13'b0000010000000,
        S_ACCP   = 13'b0000100000000,
        S_ACCF   = 13'b0001000000000,
        S_DIVDW  = 13'b0010000000000,
        S_SUM    = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_stat.run) begin
                    n_state = S_FIN;
                end else if (i_stat.stopped) begin
                    o_cmd.zero_speed = 1'b1;
                    n_state          = S_ERR;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MS_CHANGE;
                    n_state       = S_DIVS;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVSW;
            end
            S_DIVSW: begin
                if (i_stat.div_done) begin
                    o_cmd.speed_load = 1'b1;
                    n_state          = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err_load = 1'b1;
                n_state        = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_INTEG;
                n_state       = S_ACCI;
            end
            S_ACCI: begin
                o_cmd.integ_load = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MS_DERIV;
                n_state          = S_DIVD;
            end
            S_DIVD: begin
                // derivative division runs while the other terms are summed
                o_cmd.div_start = 1'b1;
                o_cmd.div_deriv = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MS_PROP;
                n_state         = S_ACCP;
            end
            S_ACCP: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_FF;
                n_state        = S_ACCF;
            end
            S_ACCF: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_DIVDW;
            end
            S_DIVDW: begin
                if (i_stat.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/motor_speed_pid_regulator.sv]
// Coast, brake, hold and a speed poll inside its sample period go from decide straight to
// the result; a speed update measures the speed (no speed division right after coast or
// brake), then forms the PID terms, and the result may then wait for ready.
// A new request is taken only once the last result is registered. The shared 49-step
// restoring divider serves both the speed and the derivative division of an update.
// Reset (synchronous, active low) clears gains, sets a 1 ms period, zeroes the loop
// state and selects coast; no clearing pass is needed.
`include "motor_speed_pid_regulator_defines.svh"
module motor_speed_pid_regulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_mode,
    input  logic signed [msp_pkg::TGT_W-1:0] i_target_speed,
    input  logic signed [msp_pkg::POS_W-1:0] i_encoder_count,
    input  logic [msp_pkg::TIME_W-1:0]       i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [msp_pkg::DUTY_W-1:0]       o_fwd_duty,
    output logic [msp_pkg::DUTY_W-1:0]       o_rev_duty,
    output logic                             o_braking,
    output logic                             o_acted,
    output logic signed [msp_pkg::ERR_W-1:0] o_speed_error
);
    import msp_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [DIV_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic [DIV_W-1:0] w_quot;
    logic             w_div_done;

    msp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    msp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    msp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_target_speed  (i_target_speed),
        .i_encoder_count (i_encoder_count),
        .i_now_ms        (i_now_ms),
        .o_div_dividend  (w_dividend),
        .o_div_divisor   (w_divisor),
        .i_div_quot      (w_quot),
        .i_div_done      (w_div_done),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fwd_duty      (o_fwd_duty),
        .o_rev_duty      (o_rev_duty),
        .o_braking       (o_braking),
        .o_acted         (o_acted),
        .o_speed_error   (o_speed_error)
    );

    `MSP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "request accepted while busy")
    `MSP_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready), "result without a request in flight")
    `MSP_ASSERT(a_drive_shape, i_clk, i_rst_n, o_out_valid |-> (o_braking ? (o_fwd_duty == DUTY_FULL && o_rev_duty == DUTY_FULL) : (o_fwd_duty == '0 || o_rev_duty == '0)), "both pins driven outside brake")
    `MSP_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
